>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/rtj_pkg.sv
// Types, codes and helper functions of the record text to JSON converter.
`default_nettype none
package rtj_pkg;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_CR   = 3'd1;
    localparam logic [2:0] MODE_KEY  = 3'd2;
    localparam logic [2:0] MODE_WORD = 3'd3;
    localparam logic [2:0] MODE_NUM  = 3'd4;
    localparam logic [2:0] MODE_STR  = 3'd5;

    localparam logic [1:0] PH_KEY  = 2'd0;
    localparam logic [1:0] PH_VAL  = 2'd1;
    localparam logic [1:0] PH_LIST = 2'd2;

    localparam logic KIND_REC  = 1'b0;
    localparam logic KIND_LIST = 1'b1;

    localparam logic [2:0] ST_BYTE     = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_BAD_TOK  = 3'd2;
    localparam logic [2:0] ST_BAD_END  = 3'd3;
    localparam logic [2:0] ST_TOO_DEEP = 3'd4;

    localparam logic [3:0] WM_DEAD = 4'd15;
    localparam logic [3:0] WM_TRUE_START  = 4'd1;
    localparam logic [3:0] WM_FALSE_START = 4'd5;
    localparam logic [3:0] WM_TRUE_OK  = 4'd4;
    localparam logic [3:0] WM_FALSE_OK = 4'd9;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_NONE   = 8'h00;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  status;
        logic [15:0] err_line;
        logic [15:0] err_col;
        logic        last;
    } entry_t;

    function automatic entry_t mk_byte(input logic [7:0] b);
        entry_t e;
        e.out_byte = b;
        e.status   = ST_BYTE;
        e.err_line = 16'd0;
        e.err_col  = 16'd0;
        e.last     = 1'b0;
        return e;
    endfunction

    function automatic entry_t mk_term(input logic [2:0] st, input logic [15:0] ln,
                                       input logic [15:0] cl);
        entry_t e;
        e.out_byte = 8'd0;
        e.status   = st;
        e.err_line = ln;
        e.err_col  = cl;
        e.last     = 1'b1;
        return e;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_numeral(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_ident(input logic [7:0] b);
        return is_letter(b) || is_numeral(b) || b == CH_UNDER;
    endfunction

    // Expected next letter of "true" (from 1) or "false" (from 5); zero where none.
    function automatic logic [7:0] wm_char(input logic [3:0] wm);
        case (wm)
            4'd1:    return 8'h72;
            4'd2:    return 8'h75;
            4'd3:    return 8'h65;
            4'd5:    return 8'h61;
            4'd6:    return 8'h6C;
            4'd7:    return 8'h73;
            4'd8:    return 8'h65;
            default: return CH_NONE;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> rtl/record_text_to_json_converter_core.sv
// Results of an accepted item are queued, then pass through out_reg to the m_ outputs.
// A new item is taken only once the queue has emptied and no pop or close is in progress.
// End of input closes each open list, one nesting-stack memory read per level.
// A closed record or list reads the enclosing kind back while its bytes drain, at no cost.
// Reset (synchronous, active low) returns to the root record; the stack needs no clearing.
`default_nettype none
module record_text_to_json_converter_core #(
    parameter int NEST_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [7:0]  s_src_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic [2:0]       m_status,
    output logic [15:0]      m_err_line,
    output logic [15:0]      m_err_col,
    output logic             m_last
);
    localparam int LW = $clog2(NEST_DEPTH + 1);
    localparam int AW = $clog2(NEST_DEPTH);

    typedef enum logic [1:0] {S_RUN, S_CLOSE, S_CLWAIT} state_t;

    state_t          state_reg, state_next;
    logic [2:0]      lex_mode_reg, lex_mode_next;
    logic [1:0]      parse_phase_reg, parse_phase_next;
    logic            first_item_reg, first_item_next;
    logic [LW-1:0]   nest_level_reg, nest_level_next;
    logic [3:0]      word_match_reg, word_match_next;
    logic [15:0]     cur_line_reg, cur_line_next, cur_col_reg, cur_col_next;
    logic [15:0]     tok_line_reg, tok_line_next, tok_col_reg, tok_col_next;
    logic [15:0]     end_line_reg, end_line_next, end_col_reg, end_col_next;
    logic            finished_reg, finished_next;
    logic            top_kind_reg, top_kind_next;
    logic            pop_fix_reg, pop_fix_next;

    rtj_pkg::entry_t q_reg [4];
    rtj_pkg::entry_t ld [4];
    logic [2:0]      qcnt_reg, ld_n;
    logic            load;
    rtj_pkg::entry_t out_reg;
    logic            m_valid_reg;

    logic            kind_mem [NEST_DEPTH];
    logic            mem_rd_reg;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic            wr_en, wr_kind;

    logic            accept, tok, stop, term, bracket_kind;
    logic [7:0]      b, pfx;
    logic [15:0]     eline, ecol;
    logic            out_take;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_RUN) && (qcnt_reg == 3'd0) && !pop_fix_reg;
    assign out_take = (!m_valid_reg || m_ready) && (qcnt_reg != 3'd0);

    assign m_valid    = m_valid_reg;
    assign m_out_byte = out_reg.out_byte;
    assign m_status   = out_reg.status;
    assign m_err_line = out_reg.err_line;
    assign m_err_col  = out_reg.err_col;
    assign m_last     = out_reg.last;

    always_comb begin
        state_next       = state_reg;
        lex_mode_next    = lex_mode_reg;
        parse_phase_next = parse_phase_reg;
        first_item_next  = first_item_reg;
        nest_level_next  = nest_level_reg;
        word_match_next  = word_match_reg;
        cur_line_next    = cur_line_reg;
        cur_col_next     = cur_col_reg;
        tok_line_next    = tok_line_reg;
        tok_col_next     = tok_col_reg;
        end_line_next    = end_line_reg;
        end_col_next     = end_col_reg;
        finished_next    = finished_reg;
        top_kind_next    = top_kind_reg;
        pop_fix_next     = 1'b0;
        for (int i = 0; i < 4; i++) ld[i] = rtj_pkg::mk_byte(rtj_pkg::CH_NONE);
        ld_n    = 3'd0;
        load    = 1'b0;
        rd_addr = '0;
        wr_addr = '0;
        wr_en   = 1'b0;
        wr_kind = rtj_pkg::KIND_REC;
        tok     = 1'b0;
        stop    = 1'b0;
        term    = 1'b0;
        pfx     = rtj_pkg::CH_NONE;
        bracket_kind = rtj_pkg::KIND_REC;
        eline   = cur_line_reg;
        ecol    = cur_col_reg;
        b       = s_src_byte;

        // A popped level's enclosing kind arrives from the registered stack read in the next cycle.
        if (pop_fix_reg) begin
            top_kind_next    = (nest_level_reg == '0) ? rtj_pkg::KIND_REC : mem_rd_reg;
            parse_phase_next = (top_kind_next == rtj_pkg::KIND_REC) ? rtj_pkg::PH_KEY
                                                                    : rtj_pkg::PH_LIST;
        end

        if (accept && !finished_reg) begin
            load = 1'b1;
            if (s_command) begin
                case (lex_mode_reg)
                    rtj_pkg::MODE_KEY: begin
                        ld[ld_n[1:0]] = rtj_pkg::mk_byte(rtj_pkg::CH_QUOTE);
                        ld_n = ld_n + 3'd1;
                        parse_phase_next = rtj_pkg::PH_VAL;
                    end
                    rtj_pkg::MODE_WORD: begin
                        if (word_match_reg != rtj_pkg::WM_TRUE_OK &&
                            word_match_reg != rtj_pkg::WM_FALSE_OK) begin
                            ld[ld_n[1:0]] = rtj_pkg::mk_term(rtj_pkg::ST_BAD_TOK,
                                                             tok_line_reg, tok_col_reg);
                            ld_n = ld_n + 3'd1;
                            term = 1'b1;
                            stop = 1'b1;
                        end else begin
                            first_item_next  = 1'b0;
                            parse_phase_next = (top_kind_reg == rtj_pkg::KIND_REC) ?
                                               rtj_pkg::PH_KEY : rtj_pkg::PH_LIST;
                        end
                    end
                    rtj_pkg::MODE_NUM: begin
                        first_item_next  = 1'b0;
                        parse_phase_next = (top_kind_reg == rtj_pkg::KIND_REC) ?
                                           rtj_pkg::PH_KEY : rtj_pkg::PH_LIST;
                    end
                    rtj_pkg::MODE_STR: begin
                        ld[ld_n[1:0]] = rtj_pkg::mk_term(rtj_pkg::ST_BAD_END,
                                                         tok_line_reg, tok_col_reg);
                        ld_n = ld_n + 3'd1;
                        term = 1'b1;
                        stop = 1'b1;
                    end
                    rtj_pkg::MODE_CR: begin
                        eline = tok_line_reg;
                        ecol  = tok_col_reg;
                    end
                    default: begin
                    end
                endcase
                if (!stop) begin
                    lex_mode_next = rtj_pkg::MODE_IDLE;
                    if (parse_phase_next == rtj_pkg::PH_VAL) begin
                        ld[ld_n[1:0]] = rtj_pkg::mk_term(rtj_pkg::ST_BAD_END, eline, ecol);
                        ld_n = ld_n + 3'd1;
                        term = 1'b1;
                    end else begin
                        end_line_next = eline;
                        end_col_next  = ecol;
                        state_next    = S_CLOSE;
                    end
                end
            end else begin
                case (lex_mode_reg)
                    rtj_pkg::MODE_KEY: begin
                        if (rtj_pkg::is_ident(b)) begin
                            ld[ld_n[1:0]] = rtj_pkg::mk_byte(b);
                            ld_n = ld_n + 3'd1;
                            cur_col_next = rtj_pkg::sat_inc(cur_col_reg);
                        end else begin
                            ld[ld_n[1:0]] = rtj_pkg::mk_byte(rtj_pkg::CH_QUOTE);
                            ld_n = ld_n + 3'd1;
                            parse_phase_next = rtj_pkg::PH_VAL;
                            lex_mode_next    = rtj_pkg::MODE_IDLE;
                            tok = 1'b1;
                        end
                    end
                    rtj_pkg::MODE_WORD: begin
                        if (rtj_pkg::is_ident(b)) begin
                            if (rtj_pkg::wm_char(word_match_reg) != rtj_pkg::CH_NONE &&
                                b == rtj_pkg::wm_char(word_match_reg))
                                word_match_next = word_match_reg + 4'd1;
                            else
                                word_match_next = rtj_pkg::WM_DEAD;
                            ld[ld_n[1:0]] = rtj_pkg::mk_byte(b);
                            ld_n = ld_n + 3'd1;
                            cur_col_next = rtj_pkg::sat_inc(cur_col_reg);
                        end else if (word_match_reg != rtj_pkg::WM_TRUE_OK &&
                                     word_match_reg != rtj_pkg::WM_FALSE_OK) begin
                            ld[ld_n[1:0]] = rtj_pkg::mk_term(rtj_pkg::ST_BAD_TOK,
                                                             tok_line_reg, tok_col_reg);
                            ld_n = ld_n + 3'd1;
                            term = 1'b1;
                        end else begin
                            lex_mode_next    = rtj_pkg::MODE_IDLE;
                            first_item_next  = 1'b0;
                            parse_phase_next = (top_kind_reg == rtj_pkg::KIND_REC) ?
                                               rtj_pkg::PH_KEY : rtj_pkg::PH_LIST;
                            tok = 1'b1;
                        end
                    end
                    rtj_pkg::MODE_NUM: begin
                        if (rtj_pkg::is_numeral(b) || b == rtj_pkg::CH_UNDER) begin
                            ld[ld_n[1:0]] = rtj_pkg::mk_byte(b);
                            ld_n = ld_n + 3'd1;
                            cur_col_next = rtj_pkg::sat_inc(cur_col_reg);
                        end else begin
                            lex_mode_next    = rtj_pkg::MODE_IDLE;
                            first_item_next  = 1'b0;
                            parse_phase_next = (top_kind_reg == rtj_pkg::KIND_REC) ?
                                               rtj_pkg::PH_KEY : rtj_pkg::PH_LIST;
                            tok = 1'b1;
                        end
                    end
                    rtj_pkg::MODE_STR: begin
                        ld[ld_n[1:0]] = rtj_pkg::mk_byte(b);
                        ld_n = ld_n + 3'd1;
                        cur_col_next = rtj_pkg::sat_inc(cur_col_reg);
                        if (b == rtj_pkg::CH_QUOTE) begin
                            lex_mode_next    = rtj_pkg::MODE_IDLE;
                            first_item_next  = 1'b0;
                            parse_phase_next = (top_kind_reg == rtj_pkg::KIND_REC) ?
                                               rtj_pkg::PH_KEY : rtj_pkg::PH_LIST;
                        end
                    end
                    default: tok = 1'b1;
                endcase

                // Start of a new token.
                if (tok) begin
                    if (lex_mode_reg != rtj_pkg::MODE_CR) begin
                        tok_line_next = cur_line_next;
                        tok_col_next  = cur_col_next;
                    end
                    if (b == rtj_pkg::CH_CR) begin
                        lex_mode_next = rtj_pkg::MODE_CR;
                        cur_col_next  = rtj_pkg::sat_inc(cur_col_next);
                    end else if (b == rtj_pkg::CH_LF) begin
                        lex_mode_next = rtj_pkg::MODE_IDLE;
                        cur_line_next = rtj_pkg::sat_inc(cur_line_next);
                        cur_col_next  = 16'd1;
                    end else begin
                        lex_mode_next = rtj_pkg::MODE_IDLE;
                        cur_col_next  = rtj_pkg::sat_inc(cur_col_next);
                        if (b != rtj_pkg::CH_SPACE && b != rtj_pkg::CH_TAB) begin
                            case (parse_phase_next)
                                rtj_pkg::PH_KEY: begin
                                    if (rtj_pkg::is_letter(b)) begin
                                        if (!first_item_next) begin
                                            ld[ld_n[1:0]] = rtj_pkg::mk_byte(rtj_pkg::CH_COMMA);
                                            ld_n = ld_n + 3'd1;
                                        end
                                        ld[ld_n[1:0]] = rtj_pkg::mk_byte(rtj_pkg::CH_QUOTE);
                                        ld_n = ld_n + 3'd1;
                                        ld[ld_n[1:0]] = rtj_pkg::mk_byte(b);
                                        ld_n = ld_n + 3'd1;
                                        lex_mode_next = rtj_pkg::MODE_KEY;
                                    end else if (b == rtj_pkg::CH_RBRACE) begin
                                        ld[ld_n[1:0]] = rtj_pkg::mk_byte(rtj_pkg::CH_RBRACE);
                                        ld_n = ld_n + 3'd1;
                                        if (nest_level_next == '0) begin
                                            ld[ld_n[1:0]] = rtj_pkg::mk_term(
                                                rtj_pkg::ST_COMPLETE, 16'd0, 16'd0);
                                            ld_n = ld_n + 3'd1;
                                            term = 1'b1;
                                        end else begin
                                            nest_level_next = nest_level_next - LW'(1);
                                            first_item_next = 1'b0;
                                            pop_fix_next    = 1'b1;
                                        end
                                    end else begin
                                        ld[ld_n[1:0]] = rtj_pkg::mk_term(rtj_pkg::ST_BAD_TOK,
                                                                 tok_line_next, tok_col_next);
                                        ld_n = ld_n + 3'd1;
                                        term = 1'b1;
                                    end
                                end
                                rtj_pkg::PH_VAL: pfx = rtj_pkg::CH_COLON;
                                rtj_pkg::PH_LIST: begin
                                    if (b == rtj_pkg::CH_RBRACK) begin
                                        ld[ld_n[1:0]] = rtj_pkg::mk_byte(rtj_pkg::CH_RBRACK);
                                        ld_n = ld_n + 3'd1;
                                        if (nest_level_next != '0)
                                            nest_level_next = nest_level_next - LW'(1);
                                        first_item_next = 1'b0;
                                        pop_fix_next    = 1'b1;
                                    end else if (!first_item_next) begin
                                        pfx = rtj_pkg::CH_COMMA;
                                    end
                                end
                                default: begin
                                    ld[ld_n[1:0]] = rtj_pkg::mk_term(rtj_pkg::ST_BAD_TOK,
                                                             tok_line_next, tok_col_next);
                                    ld_n = ld_n + 3'd1;
                                    term = 1'b1;
                                end
                            endcase

                            // Start of a value, after a key or inside a list.
                            if (parse_phase_next == rtj_pkg::PH_VAL ||
                                (parse_phase_next == rtj_pkg::PH_LIST &&
                                 b != rtj_pkg::CH_RBRACK)) begin
                                if (rtj_pkg::is_letter(b) || rtj_pkg::is_numeral(b) ||
                                    b == rtj_pkg::CH_QUOTE) begin
                                    if (pfx != rtj_pkg::CH_NONE) begin
                                        ld[ld_n[1:0]] = rtj_pkg::mk_byte(pfx);
                                        ld_n = ld_n + 3'd1;
                                    end
                                    ld[ld_n[1:0]] = rtj_pkg::mk_byte(b);
                                    ld_n = ld_n + 3'd1;
                                    if (rtj_pkg::is_letter(b)) begin
                                        word_match_next = (b == rtj_pkg::CH_T) ?
                                            rtj_pkg::WM_TRUE_START :
                                            (b == rtj_pkg::CH_F) ? rtj_pkg::WM_FALSE_START :
                                            rtj_pkg::WM_DEAD;
                                        lex_mode_next = rtj_pkg::MODE_WORD;
                                    end else if (rtj_pkg::is_numeral(b)) begin
                                        lex_mode_next = rtj_pkg::MODE_NUM;
                                    end else begin
                                        lex_mode_next = rtj_pkg::MODE_STR;
                                    end
                                end else if (b == rtj_pkg::CH_LBRACE ||
                                             b == rtj_pkg::CH_LBRACK) begin
                                    bracket_kind = (b == rtj_pkg::CH_LBRACK);
                                    if (nest_level_next >= LW'(NEST_DEPTH)) begin
                                        ld[ld_n[1:0]] = rtj_pkg::mk_term(rtj_pkg::ST_TOO_DEEP,
                                                                 tok_line_next, tok_col_next);
                                        ld_n = ld_n + 3'd1;
                                        term = 1'b1;
                                    end else begin
                                        if (pfx != rtj_pkg::CH_NONE) begin
                                            ld[ld_n[1:0]] = rtj_pkg::mk_byte(pfx);
                                            ld_n = ld_n + 3'd1;
                                        end
                                        ld[ld_n[1:0]] = rtj_pkg::mk_byte(b);
                                        ld_n = ld_n + 3'd1;
                                        wr_en   = 1'b1;
                                        wr_addr = AW'(nest_level_next);
                                        wr_kind = bracket_kind;
                                        nest_level_next  = nest_level_next + LW'(1);
                                        first_item_next  = 1'b1;
                                        top_kind_next    = bracket_kind;
                                        parse_phase_next = bracket_kind ? rtj_pkg::PH_LIST
                                                                        : rtj_pkg::PH_KEY;
                                    end
                                end else begin
                                    ld[ld_n[1:0]] = rtj_pkg::mk_term(rtj_pkg::ST_BAD_TOK,
                                                             tok_line_next, tok_col_next);
                                    ld_n = ld_n + 3'd1;
                                    term = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            if (term)
                finished_next = 1'b1;
            else if (ld_n != 3'd0 && state_next == S_RUN)
                ld[ld_n[1:0] - 2'd1].last = 1'b1;
            if (pop_fix_next && nest_level_next != '0)
                rd_addr = AW'(nest_level_next - LW'(1));
        end

        // End of input: close open lists one level at a time, then the root or a bad end.
        case (state_reg)
            S_CLOSE: begin
                if (qcnt_reg == 3'd0) begin
                    load = 1'b1;
                    if (nest_level_reg != '0 && top_kind_reg == rtj_pkg::KIND_LIST) begin
                        ld[0] = rtj_pkg::mk_byte(rtj_pkg::CH_RBRACK);
                        ld_n  = 3'd1;
                        nest_level_next = nest_level_reg - LW'(1);
                        if (nest_level_next != '0)
                            rd_addr = AW'(nest_level_next - LW'(1));
                        state_next = S_CLWAIT;
                    end else if (nest_level_reg == '0) begin
                        ld[0] = rtj_pkg::mk_byte(rtj_pkg::CH_RBRACE);
                        ld[1] = rtj_pkg::mk_term(rtj_pkg::ST_COMPLETE, 16'd0, 16'd0);
                        ld_n  = 3'd2;
                        finished_next = 1'b1;
                        state_next    = S_RUN;
                    end else begin
                        ld[0] = rtj_pkg::mk_term(rtj_pkg::ST_BAD_END, end_line_reg,
                                                 end_col_reg);
                        ld_n  = 3'd1;
                        finished_next = 1'b1;
                        state_next    = S_RUN;
                    end
                end
            end
            S_CLWAIT: begin
                top_kind_next = (nest_level_reg == '0) ? rtj_pkg::KIND_REC : mem_rd_reg;
                state_next    = S_CLOSE;
            end
            default: begin
            end
        endcase
    end

    // Nesting-kind stack: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en)
            kind_mem[wr_addr] <= wr_kind;
        mem_rd_reg <= kind_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_RUN;
            lex_mode_reg    <= rtj_pkg::MODE_IDLE;
            parse_phase_reg <= rtj_pkg::PH_KEY;
            first_item_reg  <= 1'b1;
            nest_level_reg  <= '0;
            word_match_reg  <= 4'd0;
            cur_line_reg    <= 16'd1;
            cur_col_reg     <= 16'd1;
            tok_line_reg    <= 16'd1;
            tok_col_reg     <= 16'd1;
            finished_reg    <= 1'b0;
            top_kind_reg    <= rtj_pkg::KIND_REC;
            pop_fix_reg     <= 1'b0;
            qcnt_reg        <= 3'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            lex_mode_reg    <= lex_mode_next;
            parse_phase_reg <= parse_phase_next;
            first_item_reg  <= first_item_next;
            nest_level_reg  <= nest_level_next;
            word_match_reg  <= word_match_next;
            cur_line_reg    <= cur_line_next;
            cur_col_reg     <= cur_col_next;
            tok_line_reg    <= tok_line_next;
            tok_col_reg     <= tok_col_next;
            finished_reg    <= finished_next;
            top_kind_reg    <= top_kind_next;
            pop_fix_reg     <= pop_fix_next;
            // Loads only happen with the queue empty, so they never meet a dequeue.
            if (load) begin
                qcnt_reg <= ld_n;
                for (int i = 0; i < 4; i++) q_reg[i] <= ld[i];
            end else if (out_take) begin
                qcnt_reg <= qcnt_reg - 3'd1;
                for (int i = 0; i < 3; i++) q_reg[i] <= q_reg[i + 1];
            end
            if (out_take)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
        end_line_reg <= end_line_next;
        end_col_reg  <= end_col_next;
        if (out_take)
            out_reg <= q_reg[0];
    end

endmodule
`default_nettype wire

>>> rtl/rtj_chk.sv
// Port-level checker for the converter, bound to the converter core.
`default_nettype none
`include "assert_macros.svh"
module rtj_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_out_byte,
    input wire logic [2:0]  m_status,
    input wire logic [15:0] m_err_line,
    input wire logic [15:0] m_err_col,
    input wire logic        m_last
);
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_status))
    `ASSERT_IMPL(a_term_last, aclk, aresetn, m_valid && m_status != rtj_pkg::ST_BYTE, m_last)
    `ASSERT_IMPL(a_byte_nopos, aclk, aresetn, m_valid && m_status == rtj_pkg::ST_BYTE, m_err_line == 16'd0 && m_err_col == 16'd0)
    `ASSERT_IMPL(a_err_pos, aclk, aresetn, m_valid && m_status > rtj_pkg::ST_COMPLETE, m_err_line != 16'd0 && m_err_col != 16'd0 && m_out_byte == 8'd0)
endmodule

bind record_text_to_json_converter_core rtj_chk u_rtj_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_status   (m_status),
    .m_err_line (m_err_line),
    .m_err_col  (m_err_col),
    .m_last     (m_last)
);
`default_nettype wire
